FILE: src/bhpq_pkg.sv
// Shared types and constants of the binary heap priority queue.
`default_nettype none

package bhpq_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 11;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_OUT_W-1:0] count_out_t;

endpackage

`default_nettype wire

FILE: src/bhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/bhpq_cmp.sv
// Shared order compare unit: tells whether one value ranks above another.
`default_nettype none

module bhpq_cmp
  import bhpq_pkg::*;
(
  input  wire value_t a,
  input  wire value_t b,
  input  wire logic   min_first,
  output logic        a_above
);

  assign a_above = min_first ? (a < b) : (a > b);

endmodule

`default_nettype wire

FILE: src/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: sequencer, root copy and result registers.
//
// Usage: a command is accepted at a rising edge with start high and busy low. func selects
// insert (item_value is pushed) or remove (the top entry is popped). Exactly one result
// follows per command: done is high for one cycle with removed_value, removed_valid,
// empty_error, full_error, top_value, top_valid and entry_count. The receiver cannot stall;
// the result must be taken in that cycle. A new command may be issued in the done cycle.
// The order bit min_first is written over the cfg_valid/cfg_ready/cfg_data channel, which
// is ready only while no command is in progress.
// An insert climbs from the new leaf: per level it reads the parent (S_UP_CHECK), then
// compares and writes a slot (S_UP_CMP), until the value no longer ranks above its parent
// or reaches the root. A removal reads the last entry (S_LOAD_LAST), then per level reads
// the left and, if present, the right child and compares (S_DN_CHECK, S_DN_LEFT,
// S_DN_RIGHT, S_DN_CMP). Refused commands and removal of the only entry skip the memory.
// No command is taken while one is in progress. The heap memory has a single read port;
// every parent or child fetch is a registered read, and one compare unit serves all steps.
// Reset empties the heap and selects max-first order; the memory itself is not cleared.
`default_nettype none

module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       func,
  input  wire value_t     item_value,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  output logic            done,
  output value_t          removed_value,
  output logic            removed_valid,
  output logic            empty_error,
  output logic            full_error,
  output value_t          top_value,
  output logic            top_valid,
  output count_out_t      entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHECK,
    S_UP_CMP,
    S_LOAD_LAST,
    S_DN_CHECK,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_CMP
  } state_t;

  state_t        state;
  logic          report;
  logic          min_first;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [AW-1:0] parent;
  logic [AW-1:0] best_idx;
  value_t        hold;
  value_t        best;
  value_t        root;
  value_t        rem_val;
  logic          rem_ok;
  logic          err_empty;
  logic          err_full;

  logic          we;
  logic [AW-1:0] waddr;
  value_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  value_t        rdata;

  value_t        cmp_a;
  value_t        cmp_b;
  logic          a_above;

  logic [KW-1:0] kid_w;
  logic [KW-1:0] right_w;
  logic [KW-1:0] count_k;
  logic          is_full;
  logic          accept;
  logic [AW-1:0] parent_next;
  logic [CW+COUNT_OUT_W-1:0] count_wide;

  bhpq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  bhpq_cmp u_cmp (
    .a        (cmp_a),
    .b        (cmp_b),
    .min_first(min_first),
    .a_above  (a_above)
  );

  assign busy        = (state != S_IDLE) || report;
  assign cfg_ready   = !busy;
  assign accept      = start && !busy;
  assign is_full     = (count == CW'(CAPACITY));
  assign kid_w       = {1'b0, pos, 1'b1};
  assign right_w     = kid_w + KW'(1);
  assign count_k     = KW'(count);
  assign parent_next = AW'((pos - AW'(1)) >> 1);
  assign count_wide  = (CW + COUNT_OUT_W)'(count);

  assign cmp_a = (state == S_DN_RIGHT) ? rdata : hold;
  assign cmp_b = (state == S_UP_CMP) ? rdata : best;

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = hold;
    re    = 1'b0;
    raddr = parent_next;
    unique case (state)
      S_IDLE: begin
        re    = accept && (func == FUNC_REMOVE) && (count > CW'(1));
        raddr = AW'(count - CW'(1));
      end
      S_UP_CHECK: begin
        we = (pos == '0);
        re = (pos != '0);
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (a_above) begin
          wdata = rdata;
        end
      end
      S_DN_CHECK: begin
        we    = (kid_w >= count_k);
        re    = (kid_w < count_k);
        raddr = kid_w[AW-1:0];
      end
      S_DN_LEFT: begin
        re    = (right_w < count_k);
        raddr = right_w[AW-1:0];
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (!a_above) begin
          wdata = best;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      report    <= 1'b0;
      done      <= 1'b0;
      min_first <= 1'b0;
      count     <= '0;
    end else begin
      done   <= 1'b0;
      report <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        min_first <= cfg_data;
      end
      if (report) begin
        done          <= 1'b1;
        removed_value <= rem_ok ? rem_val : '0;
        removed_valid <= rem_ok;
        empty_error   <= err_empty;
        full_error    <= err_full;
        top_value     <= (count != '0) ? root : '0;
        top_valid     <= (count != '0);
        entry_count   <= count_wide[COUNT_OUT_W-1:0];
      end
      if (we && (waddr == '0)) begin
        root <= wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rem_ok    <= 1'b0;
            err_empty <= 1'b0;
            err_full  <= 1'b0;
            rem_val   <= root;
            hold      <= item_value;
            if (func == FUNC_INSERT) begin
              if (is_full) begin
                err_full <= 1'b1;
                report   <= 1'b1;
              end else begin
                pos   <= AW'(count);
                count <= CW'(count + CW'(1));
                state <= S_UP_CHECK;
              end
            end else begin
              if (count == '0) begin
                err_empty <= 1'b1;
                report    <= 1'b1;
              end else begin
                rem_ok <= 1'b1;
                count  <= CW'(count - CW'(1));
                if (count == CW'(1)) begin
                  report <= 1'b1;
                end else begin
                  state <= S_LOAD_LAST;
                end
              end
            end
          end
        end
        S_UP_CHECK: begin
          parent <= parent_next;
          if (pos == '0) begin
            report <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (a_above) begin
            pos   <= parent;
            state <= S_UP_CHECK;
          end else begin
            report <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_LOAD_LAST: begin
          hold  <= rdata;
          pos   <= '0;
          state <= S_DN_CHECK;
        end
        S_DN_CHECK: begin
          if (kid_w >= count_k) begin
            report <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_DN_LEFT;
          end
        end
        S_DN_LEFT: begin
          best     <= rdata;
          best_idx <= kid_w[AW-1:0];
          if (right_w < count_k) begin
            state <= S_DN_RIGHT;
          end else begin
            state <= S_DN_CMP;
          end
        end
        S_DN_RIGHT: begin
          if (a_above) begin
            best     <= rdata;
            best_idx <= AW'(best_idx + AW'(1));
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (a_above) begin
            report <= 1'b1;
            state  <= S_IDLE;
          end else begin
            pos   <= best_idx;
            state <= S_DN_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_top_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (top_valid == (count != '0)))
    else $error("top_valid disagrees with the entry count");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_INSERT) && is_full) |=> (report && $stable(count)))
    else $error("insert into a full heap changed the count");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(we && re && (waddr == raddr)))
    else $error("read and write of the same heap slot in one cycle");

endmodule

`default_nettype wire
